### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

    // Queue capacity and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Operation codes on the command field
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // perform the operation and load the output word
    } spq_cmd_t;

endpackage

### hw/rtl/spq_ctrl.sv
// Controller for the sorted priority queue: sequences capture and execution,
// and owns both handshakes. Depends on spq_pkg.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output spq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    // Output slot can take a new word when empty or being drained now
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Execution only ever fills a free output slot
    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> out_free)
        else $error("execute while output word stalled");

    // A captured word is always followed by its execution before the next capture
    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("second capture without execution");

    // Each execution presents a result word next cycle
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid)
        else $error("execution produced no result word");

endmodule

### hw/rtl/spq_datapath.sv
// Datapath for the sorted priority queue: the entry row with parallel
// compare-and-shift insertion, head removal and the output word. Depends on spq_pkg.
module spq_datapath
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  spq_cmd_t          cmd,
    input  logic              command,
    input  logic [DATA_W-1:0] value_in,
    input  logic [DATA_W-1:0] priority_in,
    output logic              ok,
    output logic [DATA_W-1:0] value_out
);

    // Captured input word
    logic              cmd_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] pri_reg;

    // Entry row, head at index 0
    logic [DATA_W-1:0] val_arr_reg  [DEPTH];
    logic [DATA_W-1:0] val_arr_next [DEPTH];
    logic [DATA_W-1:0] pri_arr_reg  [DEPTH];
    logic [DATA_W-1:0] pri_arr_next [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Output word
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] value_out_reg;
    logic [DATA_W-1:0] value_out_next;

    logic [DEPTH-1:0]  le;
    logic [DEPTH-1:1]  prev_le;
    logic              full;
    logic              empty;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Per-slot compare: live entry ordered at or before the new priority
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && ($signed(pri_arr_reg[i]) <= $signed(pri_reg));
        end
    end

    // prev_le[i] is the flag of slot i-1; the head slot takes the new entry whenever it moves
    assign prev_le = le[DEPTH-2:0];

    // Operation
    always_comb
    begin
        val_arr_next   = val_arr_reg;
        pri_arr_next   = pri_arr_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        value_out_next = value_out_reg;
        if (cmd.exec)
        begin
            unique case (cmd_reg)
                CMD_ENQ:
                begin
                    ok_next        = !full;
                    value_out_next = '0;
                    if (!full)
                    begin
                        if (!le[0])
                        begin
                            val_arr_next[0] = val_reg;
                            pri_arr_next[0] = pri_reg;
                        end
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            if (!le[i])
                            begin
                                val_arr_next[i] = prev_le[i] ? val_reg : val_arr_reg[i-1];
                                pri_arr_next[i] = prev_le[i] ? pri_reg : pri_arr_reg[i-1];
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DEQ:
                begin
                    ok_next        = !empty;
                    value_out_next = empty ? '0 : val_arr_reg[0];
                    if (!empty)
                    begin
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            val_arr_next[i] = val_arr_reg[i+1];
                            pri_arr_next[i] = pri_arr_reg[i+1];
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            val_reg <= value_in;
            pri_reg <= priority_in;
        end
        val_arr_reg   <= val_arr_next;
        pri_arr_reg   <= pri_arr_next;
        ok_reg        <= ok_next;
        value_out_reg <= value_out_next;
    end

    assign ok        = ok_reg;
    assign value_out = value_out_reg;

    // Fill level never passes capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // Head pair stays in order
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) && (DEPTH > 1) |->
            $signed(pri_arr_reg[0]) <= $signed(pri_arr_reg[DEPTH > 1 ? 1 : 0]))
        else $error("head entries out of order");

    // Dequeue on an empty queue fails with a zero value and leaves it empty
    a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (cmd_reg == CMD_DEQ) && empty |=>
            !ok_reg && (value_out_reg == '0) && (count_reg == '0))
        else $error("dequeue on empty queue misbehaved");

    // Successful enqueue grows the queue by one
    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (cmd_reg == CMD_ENQ) && !full |=>
            ok_reg && (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not add one entry");

endmodule

### hw/rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: joins controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   channel | handshake           | fields
//   --------+---------------------+-----------------------------------
//   input   | in_valid / in_stall  | command, value_in, priority_in
//   output  | out_valid / out_stall| ok, value_out
//
// Each word takes two steps: capture, then execute; an enqueue compares against every
// stored entry in parallel and shifts by one slot, a dequeue shifts the row up by one.
// A new word is taken while the previous result still waits in the output register.
// A stalled output holds the execute step, and so the input, until it drains.
// Reset empties the queue at once; stored entries are not cleared.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [DATA_W-1:0] value_in,
    input  logic [DATA_W-1:0] priority_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [DATA_W-1:0] value_out
);

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .command     (command),
        .value_in    (value_in),
        .priority_in (priority_in),
        .ok          (ok),
        .value_out   (value_out)
    );

endmodule
